[rtl/lpqfp_pkg.sv]
package lpqfp_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int LIMIT_BITS = 32;
	localparam int FRAME_LEN_BITS = 32;

	localparam logic [LIMIT_BITS-1:0] MAX_PAYLOAD_RESET = 32'd65535;

	localparam logic [7:0] CHAR_Q = 8'h51;
	localparam logic [7:0] CHAR_BAR = 8'h7C;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam int RADIX = 10;

	typedef enum logic [2:0] {
		PH_EXPECT_Q   = 3'd0,
		PH_EXPECT_BAR = 3'd1,
		PH_DIGITS     = 3'd2,
		PH_PAYLOAD    = 3'd3,
		PH_ERROR      = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_ERROR   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} in_item_t;

endpackage

[rtl/length_prefixed_query_frame_parser.sv]
// channel  | handshake              | payload
// in       | in_valid / in_stall    | rx_byte
// out      | out_valid / out_stall  | status, data_byte, frame_last, frame_length
// cfg      | cfg_we                 | cfg_wdata (max_payload_length)
//
// one byte per cycle while out_stall is low; each byte gives one result after its transfer:
// input register, then the parse step into the result register
// arst_n clears the phase and both counters and sets the limit to 65535
// a stalled result holds; the input register still takes one byte meanwhile
module length_prefixed_query_frame_parser #(
	parameter int LENGTH_BITS = lpqfp_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            rx_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic [7:0]                            data_byte,
	output logic                                  frame_last,
	output logic [lpqfp_pkg::FRAME_LEN_BITS-1:0]  frame_length,
	input  logic                                  cfg_we,
	input  logic [lpqfp_pkg::LIMIT_BITS-1:0]      cfg_wdata
);
	import lpqfp_pkg::*;

	logic [LIMIT_BITS-1:0] max_payload_length_q;
	in_item_t              item;
	logic                  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_length_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_payload_length_q <= cfg_wdata;
		end
	end

	lpqfp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.take     (take),
		.item     (item)
	);

	lpqfp_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.take         (take),
		.limit        (max_payload_length_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.data_byte    (data_byte),
		.frame_last   (frame_last),
		.frame_length (frame_length)
	);

endmodule

[rtl/lpqfp_in_stage.sv]
module lpqfp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                take,
	output lpqfp_pkg::in_item_t item
);
	import lpqfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       load;

	assign in_stall = valid_s1 && !take;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.rx_byte = byte_s1;

endmodule

[rtl/lpqfp_parser.sv]
module lpqfp_parser #(
	parameter int LENGTH_BITS = lpqfp_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lpqfp_pkg::in_item_t                   item,
	output logic                                  take,
	input  logic [lpqfp_pkg::LIMIT_BITS-1:0]      limit,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic [7:0]                            data_byte,
	output logic                                  frame_last,
	output logic [lpqfp_pkg::FRAME_LEN_BITS-1:0]  frame_length
);
	import lpqfp_pkg::*;

	localparam int EW = ((LENGTH_BITS > LIMIT_BITS) ? LENGTH_BITS : LIMIT_BITS) + 4;
	localparam logic [EW-1:0] LEN_MASK_EXT = EW'({LENGTH_BITS{1'b1}});

	phase_t                 phase_q, phase_nxt;
	logic [LENGTH_BITS-1:0] declared_q, declared_nxt;
	logic [LENGTH_BITS-1:0] received_q, received_nxt;

	logic                   valid_s2;
	status_t                status_s2, status_nxt;
	logic [7:0]             data_s2, data_nxt;
	logic                   last_s2, last_nxt;
	logic [FRAME_LEN_BITS-1:0] len_s2;

	logic [7:0]             b;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [EW-1:0]          decl_ext;
	logic [EW-1:0]          acc_ext;
	logic [EW-1:0]          lim_ext;
	logic [EW-1:0]          eff_limit;
	logic                   too_long;
	logic [LENGTH_BITS-1:0] received_inc;
	logic                   payload_done;
	logic                   slot_free;

	assign b = item.rx_byte;
	assign slot_free = !valid_s2 || !out_stall;
	assign take = item.valid && slot_free;

	// length accumulate: x*10 as two shifts
	assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign digit = 4'(b - CHAR_ZERO);
	assign decl_ext = EW'(declared_q);
	assign acc_ext = (decl_ext << 3) + (decl_ext << 1) + EW'(digit);
	assign lim_ext = EW'(limit);
	assign eff_limit = (lim_ext > LEN_MASK_EXT) ? LEN_MASK_EXT : lim_ext;
	assign too_long = acc_ext > eff_limit;

	assign received_inc = received_q + LENGTH_BITS'(1);
	assign payload_done = received_inc >= declared_q;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_EXPECT_Q: begin
				phase_nxt = (b == CHAR_Q) ? PH_EXPECT_BAR : PH_ERROR;
			end
			PH_EXPECT_BAR: begin
				phase_nxt = (b == CHAR_BAR) ? PH_DIGITS : PH_ERROR;
			end
			PH_DIGITS: begin
				priority if (b == CHAR_BAR) begin
					phase_nxt = (declared_q == '0) ? PH_EXPECT_Q : PH_PAYLOAD;
				end else if (is_digit && !too_long) begin
					phase_nxt = PH_DIGITS;
				end else begin
					phase_nxt = PH_ERROR;
				end
			end
			PH_PAYLOAD: begin
				phase_nxt = payload_done ? PH_EXPECT_Q : PH_PAYLOAD;
			end
			default: begin
				phase_nxt = PH_ERROR;
			end
		endcase
	end

	// result and counters
	always_comb begin
		status_nxt = ST_HEADER;
		data_nxt = '0;
		last_nxt = 1'b0;
		declared_nxt = declared_q;
		received_nxt = received_q;
		unique case (phase_q)
			PH_EXPECT_Q: begin
				if (b == CHAR_Q) begin
					declared_nxt = '0;
					received_nxt = '0;
				end else begin
					status_nxt = ST_ERROR;
				end
			end
			PH_EXPECT_BAR: begin
				if (b == CHAR_BAR) begin
					declared_nxt = '0;
				end else begin
					status_nxt = ST_ERROR;
				end
			end
			PH_DIGITS: begin
				priority if (b == CHAR_BAR) begin
					received_nxt = '0;
					last_nxt = (declared_q == '0);
				end else if (is_digit && !too_long) begin
					declared_nxt = LENGTH_BITS'(acc_ext);
				end else begin
					status_nxt = ST_ERROR;
				end
			end
			PH_PAYLOAD: begin
				status_nxt = ST_PAYLOAD;
				data_nxt = b;
				received_nxt = received_inc;
				last_nxt = payload_done;
			end
			default: begin
				status_nxt = ST_DROPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EXPECT_Q;
			declared_q <= '0;
			received_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_nxt;
				declared_q <= declared_nxt;
				received_q <= received_nxt;
			end
			if (slot_free) begin
				valid_s2 <= item.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s2 <= status_nxt;
			data_s2 <= data_nxt;
			last_s2 <= last_nxt;
			len_s2 <= FRAME_LEN_BITS'(declared_nxt);
		end
	end

	assign out_valid = valid_s2;
	assign status = status_s2;
	assign data_byte = data_s2;
	assign frame_last = last_s2;
	assign frame_length = len_s2;

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_ERROR |=> status_s2 == ST_DROPPED && phase_q == PH_ERROR)
		else $error("error phase left or wrong status");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_nxt |=> phase_q == PH_EXPECT_Q && last_s2)
		else $error("frame end without return to start");

	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> received_q < declared_q)
		else $error("payload count beyond declared length");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != ST_PAYLOAD |-> data_s2 == 8'h00)
		else $error("data byte set outside payload");

endmodule
